/* sv/mvae_pkg.sv */
package mvae_pkg;

    localparam int NumVoicesDef = 64;
    localparam int RomSize = 160;
    localparam logic [14:0] LevelMax = 15'h7fff;

    typedef enum logic [1:0] {
        ACT_KEY_ON  = 2'd0,
        ACT_KEY_OFF = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_ATTACK  = 3'd0,
        PH_DECAY   = 3'd1,
        PH_SUSTAIN = 3'd2,
        PH_RELEASE = 3'd3,
        PH_IDLE    = 3'd4
    } t_phase_code;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SUSTAIN = 3'd2;
    localparam logic [2:0] REG_REL_NRM = 3'd3;
    localparam logic [2:0] REG_REL_ALT = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] voice;
        logic [7:0] program_req;
        logic [6:0] velocity;
        logic [6:0] expression;
    } t_cmd;

    typedef struct packed {
        logic [14:0] attack_base;
        logic [14:0] decay_base;
        logic [14:0] sustain_base;
        logic [14:0] rel_normal;
        logic [14:0] rel_alt;
    } t_cfg;

    // One word of the per-voice state memory.
    typedef struct packed {
        logic [14:0] level;
        logic [2:0]  phase;
        logic [7:0]  prog;
        logic [6:0]  vel;
        logic [6:0]  expr;
    } t_voice;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_KOFF,
        BS_RD,
        BS_CALC,
        BS_VOL,
        BS_WR
    } t_bstate;

    function automatic logic [15:0] tone_word(input logic [7:0] prog);
        logic [15:0] rom [0:RomSize-1];
        rom = '{
            16'h2f72, 16'h2f72, 16'h3f72, 16'h3f72, 16'h2f80, 16'h2f80, 16'h3e80, 16'h2f80,
            16'h2e70, 16'h3740, 16'h2f80, 16'h7520, 16'h2e60, 16'h1559, 16'h3659, 16'h2e61,
            16'h7f01, 16'h7f01, 16'h7f01, 16'h7f03, 16'h7f03, 16'h7f03, 16'h7f03, 16'h7f03,
            16'h2e71, 16'h2e71, 16'h7e00, 16'h7d00, 16'h2e71, 16'h3f90, 16'h3f90, 16'h2f81,
            16'h7d21, 16'h1f80, 16'h1f80, 16'h1f90, 16'h1f70, 16'h1f70, 16'h1f71, 16'h7f61,
            16'h7f04, 16'h7f04, 16'h7f04, 16'h7f04, 16'h7f06, 16'h1649, 16'h2678, 16'h3f71,
            16'h7f06, 16'h7f06, 16'h7f06, 16'h7f06, 16'h7f04, 16'h7f03, 16'h7f03, 16'h2e64,
            16'h7f04, 16'h7f04, 16'h7f03, 16'h7f03, 16'h7f03, 16'h7f22, 16'h7f22, 16'h4f93,
            16'h6f53, 16'h6f53, 16'h6f53, 16'h6f53, 16'h7f03, 16'h7f03, 16'h7f03, 16'h7f03,
            16'h7f03, 16'h7f03, 16'h7f03, 16'h7f76, 16'h7f76, 16'h7f75, 16'h7f05, 16'h7f03,
            16'h7f01, 16'h7f01, 16'h7f74, 16'h7f82, 16'h2fb0, 16'h7f01, 16'h7f01, 16'h7f00,
            16'h7f01, 16'h7f06, 16'h7f00, 16'h7f83, 16'h7f86, 16'h7f06, 16'h7f01, 16'h7f06,
            16'h7f40, 16'h5f96, 16'h1678, 16'h7f00, 16'h7e01, 16'h7f06, 16'h7f01, 16'h7f02,
            16'h2f90, 16'h7e00, 16'h2d70, 16'h7568, 16'h1f80, 16'h7f01, 16'h7f04, 16'h7f01,
            16'h1f70, 16'h1e50, 16'h2568, 16'h1638, 16'h1568, 16'h1658, 16'h1558, 16'hf206,
            16'h7201, 16'h7404, 16'hfd06, 16'h5e80, 16'h7f00, 16'hff06, 16'hff06, 16'hac50,
            16'h7108, 16'h2428, 16'ha348, 16'h2338, 16'h7108, 16'h7109, 16'h6429, 16'hb458,
            16'h4459, 16'h3338, 16'hb348, 16'h2338, 16'h2328, 16'h2328, 16'h1328, 16'h2328,
            16'h2328, 16'h2358, 16'h2348, 16'h1428, 16'hb32b, 16'hb21a, 16'h7178, 16'h7198,
            16'h2328, 16'h2328, 16'h7108, 16'h7608, 16'h0000, 16'h0000, 16'h0000, 16'h0000
        };
        if (prog < 8'(RomSize)) begin
            return rom[prog];
        end
        return 16'h0000;
    endfunction

endpackage

/* sv/mvae_front.sv */
// Command front end: registers accepted commands into a two-entry queue.
module mvae_front
    import mvae_pkg::*;
#(
    parameter int NUM_VOICES = NumVoicesDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd       r_q [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       keep;

    // Commands that do nothing are dropped here rather than queued.
    assign keep = (i_cmd.action == ACT_TICK)
        || ((i_cmd.action == ACT_KEY_ON || i_cmd.action == ACT_KEY_OFF)
            && ({26'd0, i_cmd.voice} < 32'(NUM_VOICES)));
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && keep) begin
                r_q[r_wp] <= i_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push && keep} - {1'b0, i_pop};
        end
    end

endmodule

/* sv/mvae_back.sv */
// Voice engine: per-voice state in a registered-read memory, walked voice by voice on a tick.
// Entries that were never written read as an idle voice through a valid bit per voice.
module mvae_back
    import mvae_pkg::*;
#(
    parameter int NUM_VOICES = NumVoicesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_busy,
    input  t_cfg       i_cfg,
    output logic       o_strobe,
    output logic [5:0] o_out_voice,
    output logic [7:0] o_volume,
    output logic       o_last
);

    t_voice                r_mem [0:NUM_VOICES-1];
    t_voice                r_rdata;
    logic [NUM_VOICES-1:0] r_vld;
    logic                  r_rvld;

    t_bstate r_st, n_st;
    logic [5:0]  r_v;
    logic [15:0] r_d;
    logic [14:0] r_env;
    logic [2:0]  r_ph0;
    logic [7:0]  r_prog_l;
    logic [6:0]  r_vel_l, r_expr_l;
    logic [14:0] r_newenv;
    logic [2:0]  r_newph;
    logic        r_chg;
    logic [13:0] r_ve;
    logic [28:0] r_prod;
    logic        r_pend;
    logic [5:0]  r_pv;
    logic [7:0]  r_pvol;

    logic [14:0] c_env;
    logic [2:0]  c_ph;
    logic        last_v;
    t_voice      rd_eff;
    logic [15:0] koff_tone;
    logic        koff_ok;
    logic        mem_re, mem_we;
    logic [5:0]  rd_addr, wr_addr;
    t_voice      wr_data;

    assign last_v = ({26'd0, r_v} == 32'(NUM_VOICES - 1));
    assign o_busy = (r_st != BS_IDLE) || r_pend;

    // Read data as seen by the engine; an unwritten voice is idle with all other fields zero.
    always_comb begin
        rd_eff = r_rdata;
        if (!r_rvld) begin
            rd_eff       = '0;
            rd_eff.phase = PH_IDLE;
        end
    end

    assign koff_tone = tone_word(rd_eff.prog);
    assign koff_ok   = (rd_eff.phase <= PH_SUSTAIN) && !koff_tone[3];

    // State memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Envelope advance for one voice, falling through phases.
    always_comb begin
        logic [15:0] w;
        logic [15:0] sl;
        logic [2:0]  as, ss;
        logic [3:0]  ds;
        logic        done;
        sl    = {1'b0, r_d[14:12], 12'hfff};
        as    = r_d[2:0];
        ds    = r_d[7:4];
        ss    = r_d[10:8];
        c_env = r_env;
        c_ph  = r_ph0;
        w     = 16'd0;
        done  = 1'b1;
        if (c_ph == PH_ATTACK) begin
            done = 1'b1;
            if (as != 3'd0) begin
                w = {1'b0, c_env} + {1'b0, i_cfg.attack_base >> as};
                if (w != 16'd0 && w <= {1'b0, LevelMax}) begin
                    c_env = w[14:0];
                    done  = 1'b0;
                end
            end
            if (done) begin
                c_env = LevelMax;
                c_ph  = PH_DECAY;
            end
        end
        if (c_ph == PH_DECAY && r_ph0 <= PH_DECAY) begin
            done = 1'b1;
            if (ds != 4'd0) begin
                w = {1'b0, c_env} - {1'b0, i_cfg.decay_base >> ds};
                if (!w[15] && w > sl) begin
                    c_env = w[14:0];
                    done  = 1'b0;
                end
            end
            if (done) begin
                c_env = sl[14:0];
                c_ph  = PH_SUSTAIN;
            end
        end
        if (c_ph == PH_SUSTAIN && r_ph0 <= PH_SUSTAIN) begin
            if (ss != 3'd7) begin
                w = {1'b0, c_env} - {1'b0, i_cfg.sustain_base >> ss};
                if (!w[15] && w != 16'd0) begin
                    c_env = w[14:0];
                end else begin
                    c_env = 15'd0;
                    c_ph  = PH_IDLE;
                end
            end
        end else if (c_ph == PH_RELEASE) begin
            w = {1'b0, c_env} - {1'b0, r_d[11] ? i_cfg.rel_alt : i_cfg.rel_normal};
            if (!w[15] && w != 16'd0) begin
                c_env = w[14:0];
            end else begin
                c_env = 15'd0;
                c_ph  = PH_IDLE;
            end
        end else if (c_ph > PH_RELEASE) begin
            c_ph = r_ph0;
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BS_IDLE: begin
                if (!i_empty && !r_pend) begin
                    if (i_cmd.action == ACT_TICK) begin
                        n_st = BS_RD;
                    end else if (i_cmd.action == ACT_KEY_OFF) begin
                        n_st = BS_KOFF;
                    end
                end
            end
            BS_KOFF: n_st = BS_IDLE;
            BS_RD:   n_st = BS_CALC;
            BS_CALC: n_st = BS_VOL;
            BS_VOL:  n_st = BS_WR;
            BS_WR:   n_st = last_v ? BS_IDLE : BS_RD;
            default: n_st = BS_IDLE;
        endcase
    end

    // Queue pop and memory controls.
    always_comb begin
        o_pop   = 1'b0;
        mem_re  = 1'b0;
        mem_we  = 1'b0;
        rd_addr = r_v + 6'd1;
        wr_addr = r_v;
        wr_data = '{level: r_newenv, phase: r_newph, prog: r_prog_l, vel: r_vel_l,
                    expr: r_expr_l};
        unique case (r_st)
            BS_IDLE: begin
                if (!i_empty && !r_pend) begin
                    o_pop   = 1'b1;
                    mem_re  = (i_cmd.action != ACT_KEY_ON);
                    rd_addr = (i_cmd.action == ACT_TICK) ? 6'd0 : i_cmd.voice;
                    if (i_cmd.action == ACT_KEY_ON) begin
                        mem_we  = 1'b1;
                        wr_addr = i_cmd.voice;
                        wr_data = '{level: 15'd0, phase: PH_ATTACK, prog: i_cmd.program_req,
                                    vel: i_cmd.velocity, expr: i_cmd.expression};
                    end
                end
            end
            BS_KOFF: begin
                mem_we        = koff_ok;
                wr_data       = rd_eff;
                wr_data.phase = PH_RELEASE;
            end
            BS_WR: begin
                mem_we = 1'b1;
                mem_re = !last_v;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= BS_IDLE;
            r_pend   <= 1'b0;
            o_strobe <= 1'b0;
            r_chg    <= 1'b0;
            r_vld    <= '0;
            r_rvld   <= 1'b0;
        end else begin
            r_st     <= n_st;
            o_strobe <= 1'b0;
            if (mem_re) begin
                r_rvld <= r_vld[rd_addr];
            end
            if (mem_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
            unique case (r_st)
                BS_IDLE: begin
                    if (o_pop) begin
                        r_v <= (i_cmd.action == ACT_TICK) ? 6'd0 : i_cmd.voice;
                        if (i_cmd.action == ACT_KEY_ON) begin
                            o_strobe    <= 1'b1;
                            o_out_voice <= i_cmd.voice;
                            o_volume    <= 8'd0;
                            o_last      <= 1'b1;
                        end
                    end else if (r_pend) begin
                        // Held-back result of the last changed voice of a tick.
                        r_pend      <= 1'b0;
                        o_strobe    <= 1'b1;
                        o_out_voice <= r_pv;
                        o_volume    <= r_pvol;
                        o_last      <= 1'b1;
                    end
                end
                BS_RD: begin
                    r_d      <= tone_word(rd_eff.prog);
                    r_env    <= rd_eff.level;
                    r_ph0    <= rd_eff.phase;
                    r_prog_l <= rd_eff.prog;
                    r_vel_l  <= rd_eff.vel;
                    r_expr_l <= rd_eff.expr;
                end
                BS_CALC: begin
                    r_newenv <= c_env;
                    r_newph  <= c_ph;
                    r_chg    <= (c_env != r_env);
                    r_ve     <= 14'(r_vel_l * r_expr_l);
                end
                BS_VOL: begin
                    r_prod <= 29'(r_ve * r_newenv);
                end
                BS_WR: begin
                    if (r_chg) begin
                        // Emit the previously pending result, then hold this one.
                        if (r_pend) begin
                            o_strobe    <= 1'b1;
                            o_out_voice <= r_pv;
                            o_volume    <= r_pvol;
                            o_last      <= 1'b0;
                        end
                        r_pend <= 1'b1;
                        r_pv   <= r_v;
                        r_pvol <= 8'((16'(r_prod[28:22]) * 16'(r_prod[28:22])) >> 8);
                    end
                    r_v <= r_v + 6'd1;
                end
                default: ;
            endcase
        end
    end

endmodule

/* sv/mvae_cfg.sv */
// Configuration register file.
module mvae_cfg
    import mvae_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_index,
    input  logic [14:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_base  <= 15'd13107;
            r_cfg.decay_base   <= 15'd2621;
            r_cfg.sustain_base <= 15'd524;
            r_cfg.rel_normal   <= 15'd655;
            r_cfg.rel_alt      <= 15'd65;
        end else if (i_valid) begin
            unique case (i_index)
                REG_ATTACK:  r_cfg.attack_base  <= i_data;
                REG_DECAY:   r_cfg.decay_base   <= i_data;
                REG_SUSTAIN: r_cfg.sustain_base <= i_data;
                REG_REL_NRM: r_cfg.rel_normal   <= i_data;
                REG_REL_ALT: r_cfg.rel_alt      <= i_data;
                default: ;
            endcase
        end
    end

endmodule

/* sv/multi_voice_adsr_envelope_top.sv */
// Channel   | Handshake             | Beat contents
// command   | start, busy           | action, voice, program_req, velocity, expression
// config    | cfg_valid, cfg_ready  | cfg_index, cfg_data
// result    | o_strobe              | out_voice, volume, last
//
// A key on gives one result, registered when the engine pops it from the queue.
// A tick visits each voice in turn through its read, calc, volume and write states; a changed
// voice's result is held until the next changed voice is written, the last one after the walk.
// Synchronous active-low reset puts all voices idle and registers at defaults.
// The receiver cannot stall; busy rises only while the two-entry command queue is full,
// and cfg_ready only while the queue and engine are empty and start is low. Action 3 and
// a key on or key off with an out-of-range voice are absorbed without result.
module multi_voice_adsr_envelope_top
    import mvae_pkg::*;
#(
    parameter int NUM_VOICES = NumVoicesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [5:0]  i_voice,
    input  logic [7:0]  i_program_req,
    input  logic [6:0]  i_velocity,
    input  logic [6:0]  i_expression,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    output logic        o_strobe,
    output logic [5:0]  o_out_voice,
    output logic [7:0]  o_volume,
    output logic        o_last
);

    t_cmd cmd_in, cmd_q;
    t_cfg cfg;
    logic full, empty, pop, engine_busy;

    assign cmd_in = '{action: i_action, voice: i_voice, program_req: i_program_req,
                      velocity: i_velocity, expression: i_expression};
    // Registers are written only when no command is queued, running or being offered,
    // so a tick always sees one consistent set of rates.
    assign cfg_ready = empty && !engine_busy && !start;
    assign busy = full;

    mvae_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cfg_valid && cfg_ready),
        .i_index(cfg_index), .i_data(cfg_data), .o_cfg(cfg)
    );

    mvae_front #(.NUM_VOICES(NUM_VOICES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !busy), .i_cmd(cmd_in),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_cmd(cmd_q)
    );

    mvae_back #(.NUM_VOICES(NUM_VOICES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_cmd(cmd_q),
        .o_pop(pop), .o_busy(engine_busy), .i_cfg(cfg), .o_strobe(o_strobe),
        .o_out_voice(o_out_voice), .o_volume(o_volume), .o_last(o_last)
    );

endmodule
